FILE: rtl/core/pba_pkg.sv
// ----------------------------------------------------------------------------
// pba_pkg
// Shared types, sizes and a helper function for the page bitmap allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

    // Map geometry: one bit per page frame, 32 frames per map word.
    localparam int WORD_W    = 32;
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int PAGE_W    = 20;
    localparam int MAP_WORDS = 32768;
    localparam int MAP_AW    = $clog2(MAP_WORDS);
    localparam int SUM_WORDS = MAP_WORDS / WORD_W;
    localparam int SUM_AW    = $clog2(SUM_WORDS);
    localparam int TOP_ROWS  = SUM_WORDS / WORD_W;
    localparam int TOP_AW    = $clog2(TOP_ROWS);

    // Operation codes carried in the opcode field of an input item.
    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_MARK   = 2'd2,
        OP_UNUSED = 2'd3
    } t_opcode;

    // Write of one bit of the second-level summary.
    typedef struct packed {
        logic              valid;
        logic [SUM_AW-1:0] idx;
        logic              nonzero;
    } t_sum_upd;

    // Index of the lowest set bit of a word; zero when the word is empty.
    function automatic logic [BIT_W-1:0] lowest_bit(input logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] b;
        b = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                b = BIT_W'(i);
            end
        end
        return b;
    endfunction

endpackage

FILE: rtl/core/pba_if.sv
// ----------------------------------------------------------------------------
// pba_if
// Valid/ready channels for requests into and results out of the allocator.
// ----------------------------------------------------------------------------

// Request channel: one item per allocate, free or mark-used operation.
interface pba_in_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  opcode;
    logic [pba_pkg::PAGE_W-1:0]  page_number;

    modport source (output valid, output opcode, output page_number, input ready);
    modport sink   (input valid, input opcode, input page_number, output ready);
endinterface

// Result channel: one item per request.
interface pba_out_if;
    logic                        valid;
    logic                        ready;
    logic                        found;
    logic [pba_pkg::PAGE_W-1:0]  alloc_page;

    modport source (output valid, output found, output alloc_page, input ready);
    modport sink   (input valid, input found, input alloc_page, output ready);
endinterface

FILE: rtl/core/page_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// page_bitmap_allocator
// Physical page-frame allocator over a free bitmap with a summary tree.
// ----------------------------------------------------------------------------
// Requests arrive on i_in (opcode, page_number) and each gives exactly one
// result item on o_out (found, alloc_page). Allocate hands out the lowest free
// frame; free and mark-used set or clear one frame's bit and return zeros.
// The map lives in a 32768 x 32 RAM and a 1024 x 32 RAM holds one bit per map
// word; a 32 x 32 flip-flop array over that RAM picks the word to read.
// One request is worked on at a time. An allocate goes through the accept
// state, the summary pick with the summary RAM read, the map RAM read, and
// the write-back, which also registers its result. Free and mark-used are
// accepted with both RAM reads issued, then write back; the unused opcode
// skips the reads, writes nothing and goes straight to its result.
// After reset a clearing pass zeroes both RAMs, one map word per cycle;
// i_in.ready stays low until it ends, and every page starts out
// reserved. Results wait in an output register; a new request is accepted
// while one waits, but its write-back holds until the receiver takes the
// waiting result, so nothing is lost while o_out.ready is low.
// ----------------------------------------------------------------------------
module page_bitmap_allocator (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pba_in_if.sink    i_in,
    pba_out_if.source o_out
);
    import pba_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_FIND  = 5'b00100,
        S_L1    = 5'b01000,
        S_UPD   = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    t_opcode             r_op, n_op;
    logic                r_hit, n_hit;
    logic [MAP_AW-1:0]   r_map_addr, n_map_addr;
    logic [SUM_AW-1:0]   r_l1_addr, n_l1_addr;
    logic [BIT_W-1:0]    r_bit, n_bit;
    logic [MAP_AW-1:0]   r_clr_addr, n_clr_addr;
    logic                r_out_valid, n_out_valid;
    logic                r_out_found, n_out_found;
    logic [PAGE_W-1:0]   r_out_page, n_out_page;

    logic                map_we, map_re;
    logic [MAP_AW-1:0]   map_waddr, map_raddr;
    logic [WORD_W-1:0]   map_wdata, map_rdata;
    logic                l1_we, l1_re;
    logic [SUM_AW-1:0]   l1_waddr, l1_raddr;
    logic [WORD_W-1:0]   l1_wdata, l1_rdata;

    t_sum_upd            sum_upd;
    logic                sum_any;
    logic [SUM_AW-1:0]   sum_l1_addr;

    logic [BIT_W-1:0]    l1_bit;
    logic [BIT_W-1:0]    upd_bit;
    logic [WORD_W-1:0]   upd_mask, new_word, l1_mask, new_l1;
    logic                out_free;

    // Map words: one bit per frame.
    pba_ram #(
        .DEPTH (MAP_WORDS),
        .WIDTH (WORD_W)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_re    (map_re),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    // Summary words: one bit per nonzero map word.
    pba_ram #(
        .DEPTH (SUM_WORDS),
        .WIDTH (WORD_W)
    ) u_l1_ram (
        .i_clk   (i_clk),
        .i_we    (l1_we),
        .i_waddr (l1_waddr),
        .i_wdata (l1_wdata),
        .i_re    (l1_re),
        .i_raddr (l1_raddr),
        .o_rdata (l1_rdata)
    );

    // Upper summary levels in flip-flops.
    pba_summary u_summary (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_upd     (sum_upd),
        .o_any     (sum_any),
        .o_l1_addr (sum_l1_addr)
    );

    // Modify step: pick the bit, update the map word and its summary word.
    assign l1_bit   = lowest_bit(l1_rdata);
    assign upd_bit  = (r_op == OP_ALLOC) ? lowest_bit(map_rdata) : r_bit;
    assign upd_mask = WORD_W'(1) << upd_bit;
    assign new_word = (r_op == OP_FREE) ? (map_rdata | upd_mask) : (map_rdata & ~upd_mask);
    assign l1_mask  = WORD_W'(1) << r_map_addr[BIT_W-1:0];
    assign new_l1   = (|new_word) ? (l1_rdata | l1_mask) : (l1_rdata & ~l1_mask);
    assign out_free = !r_out_valid || o_out.ready;

    // Sequencer: clearing pass, request decode, reads and write-back.
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_hit       = r_hit;
        n_map_addr  = r_map_addr;
        n_l1_addr   = r_l1_addr;
        n_bit       = r_bit;
        n_clr_addr  = r_clr_addr;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_found = r_out_found;
        n_out_page  = r_out_page;
        map_we      = 1'b0;
        map_waddr   = r_map_addr;
        map_wdata   = new_word;
        map_re      = 1'b0;
        map_raddr   = i_in.page_number[PAGE_W-1:BIT_W];
        l1_we       = 1'b0;
        l1_waddr    = r_l1_addr;
        l1_wdata    = new_l1;
        l1_re       = 1'b0;
        l1_raddr    = i_in.page_number[PAGE_W-1:2*BIT_W];
        sum_upd     = '{valid: 1'b0, idx: r_l1_addr, nonzero: |new_l1};

        unique case (r_state)
            S_CLEAR: begin
                map_we     = 1'b1;
                map_waddr  = r_clr_addr;
                map_wdata  = '0;
                l1_we      = 1'b1;
                l1_waddr   = r_clr_addr[SUM_AW-1:0];
                l1_wdata   = '0;
                n_clr_addr = r_clr_addr + MAP_AW'(1);
                if (r_clr_addr == MAP_AW'(MAP_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in.valid) begin
                    n_op       = t_opcode'(i_in.opcode);
                    n_map_addr = i_in.page_number[PAGE_W-1:BIT_W];
                    n_l1_addr  = i_in.page_number[PAGE_W-1:2*BIT_W];
                    n_bit      = i_in.page_number[BIT_W-1:0];
                    if (t_opcode'(i_in.opcode) == OP_ALLOC) begin
                        n_state = S_FIND;
                    end else if (t_opcode'(i_in.opcode) == OP_FREE ||
                                 t_opcode'(i_in.opcode) == OP_MARK) begin
                        map_re  = 1'b1;
                        l1_re   = 1'b1;
                        n_hit   = 1'b1;
                        n_state = S_UPD;
                    end else begin
                        n_hit   = 1'b0;
                        n_state = S_UPD;
                    end
                end
            end
            S_FIND: begin
                n_hit     = sum_any;
                l1_re     = sum_any;
                l1_raddr  = sum_l1_addr;
                n_l1_addr = sum_l1_addr;
                n_state   = sum_any ? S_L1 : S_UPD;
            end
            S_L1: begin
                map_re     = 1'b1;
                map_raddr  = {r_l1_addr, l1_bit};
                n_map_addr = {r_l1_addr, l1_bit};
                n_state    = S_UPD;
            end
            S_UPD: begin
                if (out_free) begin
                    if (r_hit && r_op != OP_UNUSED) begin
                        map_we        = 1'b1;
                        l1_we         = 1'b1;
                        sum_upd.valid = 1'b1;
                    end
                    n_out_valid = 1'b1;
                    n_out_found = r_hit && (r_op == OP_ALLOC);
                    n_out_page  = n_out_found ? {r_map_addr, upd_bit} : '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_hit       <= n_hit;
        r_map_addr  <= n_map_addr;
        r_l1_addr   <= n_l1_addr;
        r_bit       <= n_bit;
        r_out_found <= n_out_found;
        r_out_page  <= n_out_page;
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.found      = r_out_found;
    assign o_out.alloc_page = r_out_page;

endmodule

FILE: rtl/core/pba_ram.sv
// ----------------------------------------------------------------------------
// pba_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pba_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/pba_summary.sv
// ----------------------------------------------------------------------------
// pba_summary
// Upper levels of the search tree: one bit per summary word in flip-flops,
// and the lowest nonempty summary word found from them.
// ----------------------------------------------------------------------------
module pba_summary (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  pba_pkg::t_sum_upd         i_upd,
    output logic                      o_any,
    output logic [pba_pkg::SUM_AW-1:0] o_l1_addr
);
    import pba_pkg::*;

    logic [WORD_W-1:0]   r_l2 [TOP_ROWS];
    logic [TOP_ROWS-1:0] row_nz;
    logic [TOP_AW-1:0]   top_idx;
    logic [BIT_W-1:0]    row_bit;

    // Bit j of row i is set when summary word i*32+j is nonzero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TOP_ROWS; i++) begin
                r_l2[i] <= '0;
            end
        end else if (i_upd.valid) begin
            r_l2[i_upd.idx[SUM_AW-1:BIT_W]][i_upd.idx[BIT_W-1:0]] <= i_upd.nonzero;
        end
    end

    // Top level: one bit per row.
    always_comb begin
        for (int i = 0; i < TOP_ROWS; i++) begin
            row_nz[i] = |r_l2[i];
        end
    end

    // Lowest nonempty row, then lowest set bit inside it.
    always_comb begin
        top_idx = '0;
        for (int i = TOP_ROWS - 1; i >= 0; i--) begin
            if (row_nz[i]) begin
                top_idx = TOP_AW'(i);
            end
        end
    end

    assign row_bit   = lowest_bit(r_l2[top_idx]);
    assign o_any     = |row_nz;
    assign o_l1_addr = {top_idx, row_bit};

endmodule
